FILE: design/cpns_pkg.sv
// ----------------------------------------------------------------------------
// cpns_pkg
// Types and constants shared by the contact penetration / normal select block.
// ----------------------------------------------------------------------------
package cpns_pkg;

	localparam int EDGE_COUNT = 4;
	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;

	// square root: two operand bits per step, operand left-aligned in 64 bits
	localparam int EDGE_ITERS = (32 + FRAC_BITS + 1) / 2;
	localparam int SQ_ALIGN   = 64 - 2 * EDGE_ITERS;
	localparam int NORM_ITERS = 32;
	localparam int UNIT_SHIFT = 30;
	localparam int DIV_STEPS  = UNIT_SHIFT + 1;
	localparam int CNT_W      = 6;

	localparam logic [31:0] PEN_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [30:0]        gap;
		logic [31:0]        edge_dist_squared;
		logic signed [31:0] edge_normal_x;
		logic signed [31:0] edge_normal_y;
		logic signed [31:0] edge_normal_z;
		logic               last_edge;
	} in_item_t;

	typedef struct packed {
		logic [30:0]        penetration;
		logic signed [31:0] unit_x;
		logic signed [31:0] unit_y;
		logic signed [31:0] unit_z;
		logic [1:0]         chosen_edge;
	} out_item_t;

	typedef struct packed {
		logic       capture;
		logic       upd;
		logic       sq_en;
		logic [1:0] sq_sel;
		logic       sqrt_norm;
		logic       div_start;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic last;
		logic out_free;
	} stat_t;

endpackage

FILE: design/cpns_ctrl.sv
// ----------------------------------------------------------------------------
// cpns_ctrl
// Sequencer: edge root, best update, normal length and normalization steps.
// ----------------------------------------------------------------------------
module cpns_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cpns_pkg::stat_t stat,
	output cpns_pkg::cmd_t  cmd
);
	import cpns_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EDGE_SQRT, ST_NRM_SQ, ST_NRM_START, ST_NRM_SQRT, ST_DIV, ST_OUT
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] sq_idx_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		in_stall  = (state_q != ST_IDLE);
		cmd.sq_sel = sq_idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EDGE_SQRT;
				end
			end
			ST_EDGE_SQRT: begin
				if (!stat.sqrt_busy) begin
					cmd.upd = 1'b1;
					state_d = stat.last ? ST_NRM_SQ : ST_IDLE;
				end
			end
			ST_NRM_SQ: begin
				cmd.sq_en = 1'b1;
				if (sq_idx_q == 2'd3)
					state_d = ST_NRM_START;
			end
			ST_NRM_START: begin
				cmd.sqrt_norm = 1'b1;
				state_d       = ST_NRM_SQRT;
			end
			ST_NRM_SQRT: begin
				if (!stat.sqrt_busy) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!stat.div_busy)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sq_idx_q <= '0;
		end else begin
			state_q  <= state_d;
			sq_idx_q <= (state_q == ST_NRM_SQ) ? sq_idx_q + 2'd1 : 2'd0;
		end
	end

endmodule

FILE: design/cpns_dp.sv
// ----------------------------------------------------------------------------
// cpns_dp
// Datapath: shared bit-serial square root, best-edge registers, squared
// length accumulator and three restoring divider lanes.
// ----------------------------------------------------------------------------
module cpns_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  cpns_pkg::in_item_t  in_item,
	input  logic                cfg_we,
	input  logic [30:0]         cfg_wdata,
	input  cpns_pkg::cmd_t      cmd,
	output cpns_pkg::stat_t     stat,
	input  logic                out_stall,
	output logic                out_valid,
	output cpns_pkg::out_item_t out_item
);
	import cpns_pkg::*;

	logic [30:0]        margin_q;
	logic [30:0]        gap_q;
	logic signed [31:0] nrm_q [3];
	logic               last_q;

	logic [POS_W-1:0]   pos_q;
	logic [30:0]        best_pen_q;
	logic signed [31:0] best_nrm_q [3];
	logic [POS_W-1:0]   best_edge_q;

	logic [63:0]        op_q;
	logic [35:0]        rem_q;
	logic [31:0]        root_q;
	logic [CNT_W-1:0]   sq_cnt_q;

	logic [31:0]        mag [3];
	logic [31:0]        sq_in;
	logic [63:0]        mul_s1;
	logic [63:0]        acc_q;

	logic [31:0]        r_q;
	logic [33:0]        drem_q [3];
	logic [30:0]        quo_q [3];
	logic [CNT_W-1:0]   div_cnt_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic [35:0] rem_nx;
	logic [35:0] trial;
	logic [31:0] t_sum;
	logic [31:0] p_raw;
	logic [30:0] p_sat;
	logic        take;

	always_comb begin
		rem_nx = {rem_q[33:0], op_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		t_sum  = {1'b0, gap_q} + {1'b0, margin_q};
		p_raw  = (t_sum > root_q) ? t_sum - root_q : 32'd0;
		p_sat  = p_raw[31] ? PEN_MAX[30:0] : p_raw[30:0];
		take   = (pos_q == '0) || (p_sat > best_pen_q);
		for (int i = 0; i < 3; i++)
			mag[i] = best_nrm_q[i][31] ? 32'(-best_nrm_q[i]) : 32'(best_nrm_q[i]);
		case (cmd.sq_sel)
			2'd0:    sq_in = mag[0];
			2'd1:    sq_in = mag[1];
			2'd2:    sq_in = mag[2];
			default: sq_in = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q    <= '0;
			pos_q       <= '0;
			best_pen_q  <= '0;
			best_edge_q <= '0;
			sq_cnt_q    <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				best_nrm_q[i] <= '0;
		end else begin
			if (cfg_we)
				margin_q <= cfg_wdata;

			// square root: load for an edge or for the normal length, then step
			if (cmd.capture) begin
				op_q     <= 64'({in_item.edge_dist_squared, {FRAC_BITS{1'b0}}}) << SQ_ALIGN;
				rem_q    <= '0;
				root_q   <= '0;
				sq_cnt_q <= CNT_W'(EDGE_ITERS);
			end else if (cmd.sqrt_norm) begin
				op_q     <= acc_q;
				rem_q    <= '0;
				root_q   <= '0;
				sq_cnt_q <= CNT_W'(NORM_ITERS);
			end else if (sq_cnt_q != '0) begin
				op_q     <= {op_q[61:0], 2'b00};
				sq_cnt_q <= sq_cnt_q - 1'b1;
				if (rem_nx >= trial) begin
					rem_q  <= rem_nx - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_nx;
					root_q <= {root_q[30:0], 1'b0};
				end
			end

			if (cmd.upd) begin
				if (take) begin
					best_pen_q  <= p_sat;
					best_edge_q <= pos_q;
					for (int i = 0; i < 3; i++)
						best_nrm_q[i] <= nrm_q[i];
				end
				if (last_q)
					pos_q <= '0;
				else if (pos_q != POS_W'(EDGE_COUNT - 1))
					pos_q <= pos_q + 1'b1;
			end

			// divider lanes: mag * 2^30 / r, one quotient bit a step
			if (cmd.div_start) begin
				div_cnt_q <= CNT_W'(DIV_STEPS);
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= {2'b00, mag[i]};
					quo_q[i]  <= '0;
				end
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				for (int i = 0; i < 3; i++) begin
					if (drem_q[i] >= {2'b00, r_q}) begin
						drem_q[i] <= {drem_q[i][32:0] - {1'b0, r_q}, 1'b0};
						quo_q[i]  <= {quo_q[i][29:0], 1'b1};
					end else begin
						drem_q[i] <= {drem_q[i][32:0], 1'b0};
						quo_q[i]  <= {quo_q[i][29:0], 1'b0};
					end
				end
			end

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gap_q    <= in_item.gap;
			nrm_q[0] <= in_item.edge_normal_x;
			nrm_q[1] <= in_item.edge_normal_y;
			nrm_q[2] <= in_item.edge_normal_z;
			last_q   <= in_item.last_edge;
		end
		if (cmd.sq_en) begin
			mul_s1 <= 64'(sq_in) * 64'(sq_in);
			acc_q  <= (cmd.sq_sel == 2'd0) ? 64'd0 : acc_q + mul_s1;
		end
		if (cmd.div_start)
			r_q <= (root_q == '0) ? 32'd1 : root_q;
		if (cmd.out_load) begin
			out_q.penetration <= best_pen_q;
			out_q.chosen_edge <= 2'(best_edge_q);
			out_q.unit_x <= best_nrm_q[0][31] ? -$signed({1'b0, quo_q[0]}) : {1'b0, quo_q[0]};
			out_q.unit_y <= best_nrm_q[1][31] ? -$signed({1'b0, quo_q[1]}) : {1'b0, quo_q[1]};
			out_q.unit_z <= best_nrm_q[2][31] ? -$signed({1'b0, quo_q[2]}) : {1'b0, quo_q[2]};
		end
	end

	assign stat.sqrt_busy = (sq_cnt_q != '0);
	assign stat.div_busy  = (div_cnt_q != '0);
	assign stat.last      = last_q;
	assign stat.out_free  = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign out_item       = out_q;

endmodule

FILE: design/contact_penetration_normal_select_top.sv
// ----------------------------------------------------------------------------
// contact_penetration_normal_select_top
// Edge penetration maximum and unit normal of the winning edge.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_item carries one edge item; a candidate
// ends with the item that has last_edge set. Output channel
// out_valid/out_stall/out_item gives one result per candidate.
// Config: cfg_we/cfg_wdata writes contact_margin; the user must do so only
// while idle, and the block itself has no check for it. Each edge item is
// accepted, then gets one root bit per cycle in the shared square root unit
// (24 steps at Q16.16), then the best-edge update. The last edge then adds
// the squared length (one shared 32x32 multiplier), its 32-step root, the
// three divider lanes (31 quotient bits) and a load of the output register,
// which raises out_valid.
// Items are taken one at a time; in_stall is high while an item is at work.
// A result waits in the output register while out_stall is high; the next
// candidate's edges are accepted meanwhile, and only the following result
// load waits for that register to empty.
// Reset clears the margin, edge position, best-edge state and out_valid.
// ----------------------------------------------------------------------------
module contact_penetration_normal_select_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cpns_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output cpns_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [30:0]         cfg_wdata
);
	import cpns_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cpns_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	cpns_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.stat     (stat),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_item (out_item)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted item did not make the block busy");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall) && !stat.div_busy)
		else $error("result loaded over a held result or before division end");

	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result load did not raise out_valid");

endmodule

FILE: dv/contact_penetration_normal_select_top_tb.sv
// ----------------------------------------------------------------------------
// contact_penetration_normal_select_top_tb
// Streams edge items through the block, predicts the penetration maximum,
// chosen edge and unit normal per candidate, and checks every result in order.
// ----------------------------------------------------------------------------
class contact_scoreboard;
	logic [30:0] margin;
	int unsigned edge_pos;
	logic [30:0] best_pen;
	logic signed [31:0] best_n [3];
	logic [1:0] best_idx;
	cpns_pkg::out_item_t pending_q[$];
	int unsigned error_count;

	function new();
		margin = 0;
		edge_pos = 0;
		best_pen = 0;
		best_n[0] = 0;
		best_n[1] = 0;
		best_n[2] = 0;
		best_idx = 0;
		error_count = 0;
	endfunction

	static function logic [63:0] root64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	static function logic [31:0] to_unit(logic signed [31:0] v, logic [63:0] len);
		logic [63:0] mag;
		logic [63:0] q;
		mag = v[31] ? (64'd0 - {{32{1'b1}}, v}) : {32'd0, v};
		q = (mag << 30) / len;
		if (v[31])
			q = 64'd0 - q;
		return q[31:0];
	endfunction

	function void note_item(cpns_pkg::in_item_t it);
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] az;
		logic [63:0] len;
		cpns_pkg::out_item_t r;
		t = {33'd0, it.gap} + {33'd0, margin};
		d = root64({32'd0, it.edge_dist_squared} << cpns_pkg::FRAC_BITS);
		p = (t > d) ? t - d : 0;
		if (p > 64'h7FFF_FFFF)
			p = 64'h7FFF_FFFF;
		if (edge_pos == 0 || p[30:0] > best_pen) begin
			best_pen = p[30:0];
			best_n[0] = it.edge_normal_x;
			best_n[1] = it.edge_normal_y;
			best_n[2] = it.edge_normal_z;
			best_idx = edge_pos[1:0];
		end
		if (!it.last_edge) begin
			if (edge_pos + 1 < cpns_pkg::EDGE_COUNT)
				edge_pos++;
			return;
		end
		ax = best_n[0][31] ? 64'd0 - {{32{1'b1}}, best_n[0]} : {32'd0, best_n[0]};
		ay = best_n[1][31] ? 64'd0 - {{32{1'b1}}, best_n[1]} : {32'd0, best_n[1]};
		az = best_n[2][31] ? 64'd0 - {{32{1'b1}}, best_n[2]} : {32'd0, best_n[2]};
		s = ax * ax + ay * ay + az * az;
		len = root64(s);
		if (len == 0)
			len = 1;
		r.penetration = best_pen;
		r.unit_x = to_unit(best_n[0], len);
		r.unit_y = to_unit(best_n[1], len);
		r.unit_z = to_unit(best_n[2], len);
		r.chosen_edge = best_idx;
		pending_q.push_back(r);
		edge_pos = 0;
	endfunction

	function void check_result(cpns_pkg::out_item_t got);
		cpns_pkg::out_item_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			error_count++;
			return;
		end
		e = pending_q.pop_front();
		if (got.penetration !== e.penetration) begin
			$display("%0t: penetration exp %h got %h", $time, e.penetration, got.penetration);
			error_count++;
		end
		if (got.unit_x !== e.unit_x) begin
			$display("%0t: unit_x exp %h got %h", $time, e.unit_x, got.unit_x);
			error_count++;
		end
		if (got.unit_y !== e.unit_y) begin
			$display("%0t: unit_y exp %h got %h", $time, e.unit_y, got.unit_y);
			error_count++;
		end
		if (got.unit_z !== e.unit_z) begin
			$display("%0t: unit_z exp %h got %h", $time, e.unit_z, got.unit_z);
			error_count++;
		end
		if (got.chosen_edge !== e.chosen_edge) begin
			$display("%0t: chosen_edge exp %h got %h", $time, e.chosen_edge, got.chosen_edge);
			error_count++;
		end
	endfunction
endclass

module contact_penetration_normal_select_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpns_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1;
	out_item_t out_item;
	logic cfg_we = 0;
	logic [30:0] cfg_wdata = '0;

	contact_scoreboard sb = new();
	int unsigned idle_cycles = 0;
	bit rx_idle_off = 0;

	contact_penetration_normal_select_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(in_item);
			if (out_valid && !out_stall)
				sb.check_result(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall with quiet stretches
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_stall <= 0;
			n = $urandom_range(1, 40);
			repeat (n) @(negedge clk);
			if (!rx_idle_off && $urandom_range(0, 2) != 0) begin
				n = gap_len();
				if (n > 0) begin
					out_stall <= 1;
					repeat (n) @(negedge clk);
				end
			end
		end
	end

	// valid stays high into the next item when there is no gap
	task automatic send_item(in_item_t it);
		int n;
		n = gap_len();
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			in_valid <= 0;
			in_item <= rand_item(0);
			repeat (n) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		in_item <= rand_item(0);
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_margin(logic [30:0] m);
		wait_drained();
		cfg_wdata <= m;
		cfg_we <= 1;
		@(negedge clk);
		cfg_we <= 0;
		sb.margin = m;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 255);
			3: return 32'h8000_0000 | $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t rand_item(bit last);
		in_item_t it;
		it.gap = 31'(rand_word());
		if ($urandom_range(0, 1))
			it.gap = 31'($urandom_range(0, 32'h00FF_FFFF));
		it.edge_dist_squared = rand_word();
		if ($urandom_range(0, 1))
			it.edge_dist_squared = $urandom_range(0, 32'h0FFF_FFFF);
		it.edge_normal_x = rand_word();
		it.edge_normal_y = rand_word();
		it.edge_normal_z = rand_word();
		it.last_edge = last;
		return it;
	endfunction

	task automatic send_candidate(int edges, bit same_dist);
		in_item_t it;
		logic [30:0] g;
		logic [31:0] d;
		g = 31'($urandom);
		d = $urandom_range(0, 32'h00FF_FFFF);
		for (int k = 0; k < edges; k++) begin
			it = rand_item(k == edges - 1);
			it.gap = g;
			if (same_dist)
				it.edge_dist_squared = d;
			send_item(it);
		end
	endtask

	initial begin
		in_item_t it;
		int edges;
		repeat (2) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: extremes, zero normal, ties, short and overlong candidates
		it = '0;
		it.last_edge = 1;
		send_item(it);
		it.gap = '1;
		it.edge_normal_x = 32'h8000_0000;
		it.edge_normal_y = 32'h7FFF_FFFF;
		it.edge_normal_z = 32'hFFFF_FFFF;
		send_item(it);
		it = '0;
		it.edge_dist_squared = '1;
		it.edge_normal_z = 32'h0001_0000;
		send_item(it);
		send_item(it);
		it.last_edge = 1;
		send_item(it);
		send_candidate(4, 1);
		send_candidate(2, 0);
		send_candidate(7, 0);
		write_margin(31'h7FFF_FFFF);
		it = '0;
		it.gap = '1;
		it.edge_normal_x = 32'h8000_0000;
		it.edge_normal_y = 32'h8000_0000;
		it.edge_normal_z = 32'h8000_0000;
		it.last_edge = 1;
		send_item(it);
		send_candidate(4, 0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_margin(31'h0);
				1: write_margin(31'($urandom_range(0, 32'h0010_0000)));
				2: write_margin(31'($urandom));
				default: write_margin(31'h7FFF_FFFF);
			endcase
			rx_idle_off = (phase == 2);
			for (int c = 0; c < 60; c++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(rand_item(1'($urandom_range(0, 1))));
				end else begin
					edges = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 4;
					send_candidate(edges, $urandom_range(0, 5) == 0);
				end
				if (c == 30)
					wait_drained();
			end
		end
		it = rand_item(1);
		send_item(it);

		wait_drained();
		if (sb.error_count == 0 && sb.pending_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
